// ===== design/ptw_pkg.sv =====
// Shared constants, codes and types for the page table build and walk block.
`default_nettype none
package ptw_pkg;
  localparam int POOL_PAGES       = 64;
  localparam int ENTRIES_PER_PAGE = 512;
  localparam int ROOT_SLOTS       = 2048;
  localparam int QUEUE_DEPTH      = 2;

  localparam int PAGE_W      = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int USED_W      = $clog2(POOL_PAGES + 1);
  localparam int ENTRY_IDX_W = $clog2(ENTRIES_PER_PAGE);
  localparam int POOL_ADDR_W = PAGE_W + ENTRY_IDX_W;
  localparam int ROOT_IDX_W  = $clog2(ROOT_SLOTS);
  localparam int VPN_W       = 11;
  localparam int PPN_W       = 44;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int PTE_V_BIT  = 0;
  localparam int PTE_U_BIT  = 4;
  localparam int PPN_LSB    = 10;
  localparam int POISON_BIT = 53;

  typedef enum logic [1:0] {
    REQ_CLEAR    = 2'd0,
    REQ_MAP_LEAF = 2'd1,
    REQ_MAP_RAW  = 2'd2,
    REQ_FIND     = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_FOUND  = 3'd1,
    ST_POOL_FULL  = 3'd2,
    ST_BLOCKED    = 3'd3,
    ST_MISALIGNED = 3'd4,
    ST_BAD_LEVEL  = 3'd5,
    ST_OUTSIDE    = 3'd6
  } status_t;

  typedef struct packed {
    req_t        req;
    logic [49:0] va;
    logic [63:0] value;
    logic [1:0]  target;
    status_t     pre_status;
  } item_t;

  typedef enum logic [3:0] {
    B_INIT, B_IDLE, B_LOOK, B_EVAL, B_ZERO, B_LINK, B_WRITE, B_CLEAR, B_DONE
  } bstate_t;
endpackage
`default_nettype wire

// ===== design/ptw_front.sv =====
// Request classifier: checks level and alignment and builds the entry to write.
`default_nettype none
module ptw_front import ptw_pkg::*; (
  input  wire logic [1:0]  paging_mode,
  input  wire logic [1:0]  req_type,
  input  wire logic [49:0] va,
  input  wire logic [55:0] pa,
  input  wire logic [9:0]  prot,
  input  wire logic        poison,
  input  wire logic [1:0]  map_level,
  input  wire logic [63:0] raw_entry,
  output item_t            item
);
  logic [63:0] leaf;
  logic        bad_level;
  logic        misaligned;

  always_comb begin
    leaf = 64'(prot) | (64'(pa[55:12]) << PPN_LSB);
    leaf[PTE_V_BIT] = 1'b1;
    if (paging_mode[1]) begin
      leaf[PTE_U_BIT] = 1'b1;
    end
    if (poison) begin
      leaf[POISON_BIT] = 1'b1;
    end
    // Three levels unless the mode selects four, so only level 3 can be out of range.
    bad_level = (map_level == 2'd3) && !paging_mode[0];
    case (map_level)
      2'd1:    misaligned = (va[20:0] != '0) || (pa[20:0] != '0);
      2'd2:    misaligned = (va[29:0] != '0) || (pa[29:0] != '0);
      2'd3:    misaligned = (va[38:0] != '0) || (pa[38:0] != '0);
      default: misaligned = 1'b0;
    endcase

    item.req        = req_t'(req_type);
    item.va         = va;
    item.value      = raw_entry;
    item.target     = 2'd0;
    item.pre_status = ST_OK;
    case (req_t'(req_type))
      REQ_MAP_LEAF: begin
        item.value  = leaf;
        item.target = map_level;
        if (bad_level) begin
          item.pre_status = ST_BAD_LEVEL;
        end else if (misaligned) begin
          item.pre_status = ST_MISALIGNED;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== design/ptw_queue.sv =====
// Short request queue between the classifier and the table walker.
`default_nettype none
module ptw_queue import ptw_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  item_t      push_item,
  input  wire logic  pop,
  output item_t      head,
  output logic       full,
  output logic       empty
);
  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/ptw_back.sv =====
// Table walker: owns the root and pool memories and carries out queued requests.
`default_nettype none
module ptw_back import ptw_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [1:0]        paging_mode,
  input  wire logic [PPN_W-1:0]  pool_base_ppn,
  input  item_t                  head,
  input  wire logic              empty,
  output logic                   pop,
  output logic                   init_busy,
  output logic                   done,
  output status_t                res_status,
  output logic [63:0]            res_value,
  output logic [1:0]             res_level
);
  bstate_t state, state_next;

  logic [63:0] root_mem [ROOT_SLOTS];
  logic [63:0] pool_mem [POOL_PAGES * ENTRIES_PER_PAGE];
  logic [63:0] root_q;
  logic [63:0] pool_q;

  item_t                 cur;
  logic [1:0]            level;
  logic [PAGE_W-1:0]     page;
  logic                  at_root;
  logic                  slot_root;
  logic [VPN_W-1:0]      slot_idx;
  logic [USED_W-1:0]     pages_used;
  logic [ROOT_IDX_W-1:0] cnt;

  logic [1:0]            top_level;
  logic [VPN_W-1:0]      idx_raw;
  logic [VPN_W-1:0]      idx;
  logic                  root_bad;
  logic [63:0]           rdata;
  logic                  pte_valid;
  logic                  pte_leaf;
  logic [PPN_W-1:0]      k;
  logic                  outside;
  logic                  pool_full;
  logic                  is_find;
  logic                  root_last;
  logic                  zero_last;
  logic [63:0]           link_pte;

  logic                   root_we, root_re, pool_we, pool_re;
  logic [ROOT_IDX_W-1:0]  root_waddr, root_raddr;
  logic [POOL_ADDR_W-1:0] pool_waddr, pool_raddr;
  logic [63:0]            root_wdata, pool_wdata;

  always_comb begin
    top_level = {1'b1, paging_mode[0]};
    case (level)
      2'd0:    idx_raw = cur.va[22:12];
      2'd1:    idx_raw = cur.va[31:21];
      2'd2:    idx_raw = cur.va[40:30];
      default: idx_raw = cur.va[49:39];
    endcase
    // The root index of the guest modes is two bits wider.
    if ((level == top_level) && paging_mode[1]) begin
      idx = idx_raw;
    end else begin
      idx = {2'b00, idx_raw[ENTRY_IDX_W-1:0]};
    end
    root_bad  = at_root && ({1'b0, idx} >= (VPN_W + 1)'(ROOT_SLOTS));
    rdata     = slot_root ? root_q : pool_q;
    pte_valid = rdata[PTE_V_BIT];
    pte_leaf  = (rdata[3:1] != 3'b000);
    k         = rdata[PPN_LSB +: PPN_W] - pool_base_ppn;
    outside   = (k >= PPN_W'(pages_used));
    pool_full = (pages_used >= USED_W'(POOL_PAGES));
    is_find   = (cur.req == REQ_FIND);
    root_last = (cnt == ROOT_IDX_W'(ROOT_SLOTS - 1));
    zero_last = (cnt[ENTRY_IDX_W-1:0] == ENTRY_IDX_W'(ENTRIES_PER_PAGE - 1));
    link_pte  = 64'(PPN_W'(pool_base_ppn + PPN_W'(pages_used))) << PPN_LSB;
    link_pte[PTE_V_BIT] = 1'b1;
  end

  always_comb begin
    state_next = state;
    case (state)
      B_INIT:  if (root_last) state_next = B_IDLE;
      B_IDLE: begin
        if (!empty) begin
          if (head.pre_status != ST_OK) begin
            state_next = B_DONE;
          end else if (head.req == REQ_CLEAR) begin
            state_next = B_CLEAR;
          end else begin
            state_next = B_LOOK;
          end
        end
      end
      B_LOOK: begin
        if (root_bad) begin
          state_next = B_DONE;
        end else if (!is_find && (level == cur.target)) begin
          state_next = B_WRITE;
        end else begin
          state_next = B_EVAL;
        end
      end
      B_EVAL: begin
        if (!pte_valid) begin
          state_next = (is_find || pool_full) ? B_DONE : B_ZERO;
        end else if (pte_leaf || (is_find && (level == 2'd0)) || outside) begin
          state_next = B_DONE;
        end else begin
          state_next = B_LOOK;
        end
      end
      B_ZERO:  if (zero_last) state_next = B_LINK;
      B_LINK:  state_next = B_LOOK;
      B_WRITE: state_next = B_DONE;
      B_CLEAR: if (root_last) state_next = B_DONE;
      B_DONE:  state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    init_busy  = 1'b0;
    done       = 1'b0;
    root_we    = 1'b0;
    root_re    = 1'b0;
    pool_we    = 1'b0;
    pool_re    = 1'b0;
    root_waddr = cnt;
    root_raddr = idx[ROOT_IDX_W-1:0];
    pool_waddr = {page, slot_idx[ENTRY_IDX_W-1:0]};
    pool_raddr = {page, idx[ENTRY_IDX_W-1:0]};
    root_wdata = '0;
    pool_wdata = '0;
    case (state)
      B_INIT: begin
        init_busy = 1'b1;
        root_we   = 1'b1;
      end
      B_CLEAR: root_we = 1'b1;
      B_IDLE:  pop = !empty;
      B_LOOK: begin
        root_re = at_root;
        pool_re = !at_root;
      end
      B_ZERO: begin
        pool_we    = 1'b1;
        pool_waddr = {pages_used[PAGE_W-1:0], cnt[ENTRY_IDX_W-1:0]};
      end
      B_LINK, B_WRITE: begin
        root_we    = slot_root;
        pool_we    = !slot_root;
        root_waddr = slot_idx[ROOT_IDX_W-1:0];
        root_wdata = (state == B_LINK) ? link_pte : cur.value;
        pool_wdata = (state == B_LINK) ? link_pte : cur.value;
      end
      B_DONE:  done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (root_we) begin
      root_mem[root_waddr] <= root_wdata;
    end
    if (root_re) begin
      root_q <= root_mem[root_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pool_we) begin
      pool_mem[pool_waddr] <= pool_wdata;
    end
    if (pool_re) begin
      pool_q <= pool_mem[pool_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_INIT;
      cnt        <= '0;
      pages_used <= '0;
    end else begin
      state <= state_next;
      case (state)
        B_INIT: cnt <= root_last ? '0 : cnt + 1'b1;
        B_CLEAR: begin
          cnt <= root_last ? '0 : cnt + 1'b1;
          if (root_last) begin
            pages_used <= '0;
          end
        end
        B_IDLE: begin
          if (!empty) begin
            cur        <= head;
            level      <= top_level;
            at_root    <= 1'b1;
            res_status <= head.pre_status;
            res_value  <= '0;
            res_level  <= '0;
          end
        end
        B_LOOK: begin
          slot_root <= at_root;
          slot_idx  <= idx;
          if (root_bad) begin
            res_status <= ST_OUTSIDE;
          end
        end
        B_EVAL: begin
          if (!pte_valid) begin
            if (is_find) begin
              res_status <= ST_NOT_FOUND;
            end else if (pool_full) begin
              res_status <= ST_POOL_FULL;
            end
          end else if (pte_leaf || (is_find && (level == 2'd0))) begin
            if (is_find) begin
              res_value <= rdata;
              res_level <= level;
            end else begin
              res_status <= ST_BLOCKED;
            end
          end else if (outside) begin
            res_status <= ST_OUTSIDE;
          end else begin
            page    <= k[PAGE_W-1:0];
            at_root <= 1'b0;
            level   <= level - 1'b1;
          end
        end
        B_ZERO: cnt <= zero_last ? '0 : cnt + 1'b1;
        B_LINK: begin
          page       <= pages_used[PAGE_W-1:0];
          at_root    <= 1'b0;
          pages_used <= pages_used + 1'b1;
          level      <= level - 1'b1;
        end
        B_WRITE: begin
          res_value <= cur.value;
          res_level <= cur.target;
        end
        default: ;
      endcase
    end
  end

  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    pages_used <= USED_W'(POOL_PAGES))
    else $error("page count beyond pool size");
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");
  a_zero_free_page: assert property (@(posedge clk) disable iff (rst)
    (state == B_ZERO) |-> (pages_used < USED_W'(POOL_PAGES)))
    else $error("zeroing a page outside the pool");
endmodule
`default_nettype wire

// ===== design/page_table_build_and_walk.sv =====
// Top level: configuration registers, classifier, request queue and table walker.
// A find reads one table entry per level walked, up to 4 levels, once the walker is idle.
// A map zeroes each new table page it takes, one entry a cycle, before linking it in.
// A clear writes the root entries, one root entry per cycle.
// Throughput: one request at a time in the walker; two more may wait in the queue.
// Reset: a pass that clears every root entry runs with busy high.
`default_nettype none
module page_table_build_and_walk import ptw_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type,
  input  wire logic [49:0] va,
  input  wire logic [55:0] pa,
  input  wire logic [9:0]  prot,
  input  wire logic        poison,
  input  wire logic [1:0]  map_level,
  input  wire logic [63:0] raw_entry,
  output logic             done,
  output logic [2:0]       status,
  output logic [63:0]      entry_value,
  output logic [1:0]       entry_level,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [43:0] cfg_data
);
  logic [1:0]       paging_mode;
  logic [PPN_W-1:0] pool_base_ppn;
  item_t            new_item;
  item_t            head;
  logic             full, empty, pop, init_busy, push;
  status_t          res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      paging_mode   <= '0;
      pool_base_ppn <= '0;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) begin
        paging_mode <= cfg_data[1:0];
      end else begin
        pool_base_ppn <= cfg_data;
      end
    end
  end

  assign busy   = full || init_busy;
  assign push   = start && !busy;
  assign status = res_status;

  ptw_front u_front (
    .paging_mode (paging_mode),
    .req_type    (req_type),
    .va          (va),
    .pa          (pa),
    .prot        (prot),
    .poison      (poison),
    .map_level   (map_level),
    .raw_entry   (raw_entry),
    .item        (new_item)
  );

  ptw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (new_item),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  ptw_back u_back (
    .clk           (clk),
    .rst           (rst),
    .paging_mode   (paging_mode),
    .pool_base_ppn (pool_base_ppn),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .init_busy     (init_busy),
    .done          (done),
    .res_status    (res_status),
    .res_value     (entry_value),
    .res_level     (entry_level)
  );
endmodule
`default_nettype wire

// ===== bench/ptw_checker.sv =====
// Checker for the page table block: predicts every request's outcome and compares results.
`timescale 1ns / 1ps
module ptw_checker import ptw_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [1:0]  req_type,
  input  wire logic [49:0] va,
  input  wire logic [55:0] pa,
  input  wire logic [9:0]  prot,
  input  wire logic        poison,
  input  wire logic [1:0]  map_level,
  input  wire logic [63:0] raw_entry,
  input  wire logic        done,
  input  wire logic [2:0]  status,
  input  wire logic [63:0] entry_value,
  input  wire logic [1:0]  entry_level,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [43:0] cfg_data,
  output int               errors,
  output int               pending
);
  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_BASE = 1'b1;

  typedef struct {
    status_t     st;
    logic [63:0] val;
    logic [1:0]  lvl;
  } outcome_t;

  logic [63:0] root_tbl [ROOT_SLOTS];
  logic [63:0] pool_mem [POOL_PAGES * ENTRIES_PER_PAGE];
  int unsigned used_pages;
  logic [1:0]  mode;
  logic [43:0] base_ppn;
  outcome_t    due_results[$];

  function automatic int level_count();
    return mode[0] ? 4 : 3;
  endfunction

  function automatic logic [10:0] table_index(logic [49:0] a, int lv);
    logic [49:0] v;
    v = a >> (12 + 9 * lv);
    if (lv == level_count() - 1 && mode[1]) return v[10:0];
    return {2'b00, v[8:0]};
  endfunction

  function automatic logic [63:0] read_entry(int page, logic [10:0] ix);
    if (page < 0) return root_tbl[ix];
    return pool_mem[page * ENTRIES_PER_PAGE + ix[8:0]];
  endfunction

  task automatic write_entry(input int page, input logic [10:0] ix, input logic [63:0] e);
    if (page < 0) root_tbl[ix] = e;
    else pool_mem[page * ENTRIES_PER_PAGE + ix[8:0]] = e;
  endtask

  // Follows a non-leaf pointer; the pool page is the PPN offset from the base, modulo 2^44.
  task automatic follow(input logic [63:0] e, inout int page, output status_t st);
    logic [43:0] k;
    k = e[53:10] - base_ppn;
    st = ST_OK;
    if (k >= used_pages) st = ST_OUTSIDE;
    else page = int'(k);
  endtask

  task automatic install(input logic [49:0] a, input logic [63:0] val, input int tgt,
                         output status_t st);
    int page;
    int lv;
    logic [10:0] ix;
    logic [63:0] e;
    logic [43:0] ppn;
    page = -1;
    st = ST_OK;
    for (lv = level_count() - 1; lv > tgt; lv--) begin
      ix = table_index(a, lv);
      if (page < 0 && ix >= ROOT_SLOTS) begin
        st = ST_OUTSIDE;
        return;
      end
      e = read_entry(page, ix);
      if (!e[0]) begin
        if (used_pages >= POOL_PAGES) begin
          st = ST_POOL_FULL;
          return;
        end
        for (int j = 0; j < ENTRIES_PER_PAGE; j++)
          pool_mem[used_pages * ENTRIES_PER_PAGE + j] = '0;
        ppn = base_ppn + 44'(used_pages);
        write_entry(page, ix, {10'd0, ppn, 10'd1});
        page = int'(used_pages);
        used_pages++;
      end else if (e[3:1] != 3'b000) begin
        st = ST_BLOCKED;
        return;
      end else begin
        follow(e, page, st);
        if (st != ST_OK) return;
      end
    end
    ix = table_index(a, tgt);
    if (page < 0 && ix >= ROOT_SLOTS) begin
      st = ST_OUTSIDE;
      return;
    end
    write_entry(page, ix, val);
  endtask

  task automatic lookup(input logic [49:0] a, output outcome_t r);
    int page;
    int lv;
    logic [10:0] ix;
    logic [63:0] e;
    status_t st;
    page = -1;
    r = '{ST_NOT_FOUND, 64'd0, 2'd0};
    for (lv = level_count() - 1; lv >= 0; lv--) begin
      ix = table_index(a, lv);
      if (page < 0 && ix >= ROOT_SLOTS) begin
        r.st = ST_OUTSIDE;
        return;
      end
      e = read_entry(page, ix);
      if (!e[0]) return;
      if (lv == 0 || e[3:1] != 3'b000) begin
        r = '{ST_OK, e, 2'(lv)};
        return;
      end
      follow(e, page, st);
      if (st != ST_OK) begin
        r.st = st;
        return;
      end
    end
  endtask

  task automatic predict_request();
    outcome_t r;
    logic [63:0] e;
    logic [49:0] amask;
    status_t st;
    r = '{ST_OK, 64'd0, 2'd0};
    case (req_t'(req_type))
      REQ_CLEAR: begin
        foreach (root_tbl[i]) root_tbl[i] = '0;
        used_pages = 0;
      end
      REQ_MAP_LEAF: begin
        amask = (50'd1 << (12 + 9 * map_level)) - 50'd1;
        e = {10'd0, pa[55:12], prot};
        e[0] = 1'b1;
        if (mode[1]) e[PTE_U_BIT] = 1'b1;
        if (poison) e[POISON_BIT] = 1'b1;
        if (map_level >= level_count()) st = ST_BAD_LEVEL;
        else if (map_level > 0 && ((va & amask) != 0 || (pa[49:0] & amask) != 0 ||
                 (map_level == 3 && pa[55:50] != 0 && 1'b0)))
          st = ST_MISALIGNED;
        else install(va, e, map_level, st);
        r.st = st;
        if (st == ST_OK) begin
          r.val = e;
          r.lvl = map_level;
        end
      end
      REQ_MAP_RAW: begin
        install(va, raw_entry, 0, st);
        r.st = st;
        if (st == ST_OK) r.val = raw_entry;
      end
      default: lookup(va, r);
    endcase
    due_results.push_back(r);
  endtask

  initial begin
    foreach (root_tbl[i]) root_tbl[i] = '0;
    used_pages = 0;
    mode = '0;
    base_ppn = '0;
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    outcome_t x;
    if (rst) begin
      foreach (root_tbl[i]) root_tbl[i] = '0;
      used_pages = 0;
      mode = '0;
      base_ppn = '0;
    end else begin
      // Results are retired before the request accepted on the same edge is predicted.
      if (done) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result status %0d value %h level %0d",
                   $realtime, status, entry_value, entry_level);
          errors = errors + 1;
        end else begin
          x = due_results.pop_front();
          if (status !== x.st) begin
            $display("%0t: status expected %0d actual %0d", $realtime, x.st, status);
            errors = errors + 1;
          end
          if (entry_value !== x.val) begin
            $display("%0t: entry_value expected %h actual %h", $realtime, x.val, entry_value);
            errors = errors + 1;
          end
          if (entry_level !== x.lvl) begin
            $display("%0t: entry_level expected %0d actual %0d",
                     $realtime, x.lvl, entry_level);
            errors = errors + 1;
          end
        end
      end
      if (start && !busy) predict_request();
      if (cfg_we) begin
        if (cfg_index == CFG_MODE) mode = cfg_data[1:0];
        else if (cfg_index == CFG_BASE) base_ppn = cfg_data;
      end
    end
    pending = due_results.size();
  end
endmodule

// ===== bench/tb_page_table_build_and_walk.sv =====
// Testbench top: drives requests and register writes to the page table block and gives the verdict.
`timescale 1ns / 1ps
module tb_page_table_build_and_walk;
  import ptw_pkg::*;

  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_BASE = 1'b1;
  localparam int   STALL_LIMIT = 30000;
  localparam logic [1:0] MODE_SV39 = 2'd0, MODE_SV48 = 2'd1, MODE_SV39X4 = 2'd2,
                         MODE_SV48X4 = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  req_type = '0;
  logic [49:0] va = '0;
  logic [55:0] pa = '0;
  logic [9:0]  prot = '0;
  logic        poison = 1'b0;
  logic [1:0]  map_level = '0;
  logic [63:0] raw_entry = '0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [43:0] cfg_data = '0;
  logic        busy, done;
  logic [2:0]  status;
  logic [63:0] entry_value;
  logic [1:0]  entry_level;
  int          errors, pending;
  int          stall_cycles = 0;
  bit          calm = 1'b0;
  logic [49:0] known_va[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  page_table_build_and_walk DUT (.*);
  ptw_checker checker_i (.*);

  // Ends a hung run: counts cycles in which neither a request nor a result moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic issue(input req_t rq, input logic [49:0] a, input logic [55:0] p,
                       input logic [9:0] pr, input logic pz, input logic [1:0] lv,
                       input logic [63:0] raw);
    bit ok;
    if (!calm && $urandom_range(99) < 12) begin
      start <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
    start <= 1'b1;
    req_type <= rq;
    va <= a;
    pa <= p;
    prot <= pr;
    poison <= pz;
    map_level <= lv;
    raw_entry <= raw;
    do begin
      @(negedge clk);
      ok = !busy;
      @(posedge clk);
    end while (!ok);
    if (rq != REQ_CLEAR && known_va.size() < 96) known_va.push_back(a);
    if (rq == REQ_CLEAR) known_va.delete();
  endtask

  // Holds the sender back until every request has its result and the walker is free.
  task automatic drain();
    bit ok;
    start <= 1'b0;
    do begin
      @(negedge clk);
      ok = (pending == 0) && !busy;
    end while (!ok);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic ix, input logic [43:0] d);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= ix;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_request();
    int pick;
    logic [49:0] a, amask;
    logic [55:0] p;
    logic [1:0]  lv;
    pick = $urandom_range(99);
    if (known_va.size() > 0 && $urandom_range(99) < 60)
      a = known_va[$urandom_range(known_va.size() - 1)] ^ 50'($urandom_range(4095));
    else if ($urandom_range(99) < 20)
      a = 50'(rand64());
    else
      a = 50'({2'($urandom_range(3)), 5'd0, 4'($urandom_range(15)), 9'($urandom_range(3)),
               9'($urandom_range(7)), 9'($urandom), 12'($urandom)}) <<
          (($urandom_range(1)) * 9);
    p = 56'(rand64());
    lv = 2'($urandom_range(3));
    if ($urandom_range(99) < 60) lv = 0;
    if ($urandom_range(99) < 85) begin
      amask = (50'd1 << (12 + 9 * lv)) - 50'd1;
      a = a & ~amask;
      p = p & ~{6'd0, amask};
    end
    if (pick < 3) issue(REQ_CLEAR, a, p, 10'($urandom), 1'($urandom), lv, rand64());
    else if (pick < 45) issue(REQ_MAP_LEAF, a, p, 10'($urandom), $urandom_range(9) == 0, lv,
                              rand64());
    else if (pick < 58) issue(REQ_MAP_RAW, a, p, 10'($urandom), 1'($urandom), lv, rand64());
    else issue(REQ_FIND, a, p, 10'($urandom), 1'($urandom), lv, rand64());
  endtask

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) begin
      calm = (i >= count / 3) && (i < count / 3 + 40);
      random_request();
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    write_reg(CFG_MODE, MODE_SV39);
    write_reg(CFG_BASE, 44'd0);

    issue(REQ_FIND, 50'h0, 56'h0, 10'h0, 1'b0, 2'd0, 64'h0);
    issue(REQ_MAP_LEAF, 50'h3FFFFFFFFF000, 56'hFFFFFFFFFFFFFF, 10'h3FF, 1'b1, 2'd0, 64'h0);
    issue(REQ_FIND, 50'h3FFFFFFFFFFFF, 56'h0, 10'h0, 1'b0, 2'd0, 64'h0);
    issue(REQ_MAP_LEAF, 50'h0000000200000, 56'h0000000400000, 10'h00E, 1'b0, 2'd1, 64'h0);
    issue(REQ_FIND, 50'h0000000212345, 56'h0, 10'h0, 1'b0, 2'd0, 64'h0);
    issue(REQ_MAP_LEAF, 50'h0000000201000, 56'h0000000400000, 10'h00E, 1'b0, 2'd0, 64'h0);
    issue(REQ_MAP_LEAF, 50'h0000000400000, 56'h0000000401000, 10'h002, 1'b0, 2'd1, 64'h0);
    issue(REQ_MAP_LEAF, 50'h0000000401000, 56'h0000000400000, 10'h002, 1'b0, 2'd1, 64'h0);
    issue(REQ_MAP_LEAF, 50'h0, 56'h0, 10'h002, 1'b0, 2'd3, 64'h0);
    issue(REQ_MAP_LEAF, 50'h0000040000000, 56'h00000C0000000, 10'h00A, 1'b0, 2'd2, 64'h0);
    issue(REQ_MAP_RAW, 50'h0000000600000, 56'h0, 10'h0, 1'b0, 2'd0, 64'hFFFFFFFFFFFFFFFF);
    issue(REQ_FIND, 50'h0000000600000, 56'h0, 10'h0, 1'b0, 2'd0, 64'h0);
    issue(REQ_MAP_RAW, 50'h0000000800000, 56'h0, 10'h0, 1'b0, 2'd0, 64'h0);
    issue(REQ_FIND, 50'h0000000800000, 56'h0, 10'h0, 1'b0, 2'd0, 64'h0);
    issue(REQ_CLEAR, 50'h0, 56'h0, 10'h0, 1'b0, 2'd0, 64'h0);
    issue(REQ_FIND, 50'h0000000212345, 56'h0, 10'h0, 1'b0, 2'd0, 64'h0);
    // Each request under a fresh root entry takes two pages, so the pool runs dry.
    for (int i = 0; i < 34; i++)
      issue(REQ_MAP_RAW, 50'(i) << 30, 56'h0, 10'h0, 1'b0, 2'd0, rand64());

    write_reg(CFG_MODE, MODE_SV48);
    write_reg(CFG_BASE, 44'hFFFFFFFFFF0);
    issue(REQ_CLEAR, 50'h0, 56'h0, 10'h0, 1'b0, 2'd0, 64'h0);
    issue(REQ_MAP_LEAF, 50'h3FF8000000000, 56'h0, 10'h001, 1'b0, 2'd3, 64'h0);
    random_phase(180);

    write_reg(CFG_MODE, MODE_SV39X4);
    write_reg(CFG_BASE, 44'(rand64()));
    issue(REQ_CLEAR, 50'h0, 56'h0, 10'h0, 1'b0, 2'd0, 64'h0);
    random_phase(180);

    // Moving the pool base without a clear makes existing pointers fall outside the pool.
    write_reg(CFG_BASE, 44'hFFFFFFFFFFF);
    random_phase(60);

    write_reg(CFG_MODE, MODE_SV48X4);
    issue(REQ_CLEAR, 50'h0, 56'h0, 10'h0, 1'b0, 2'd0, 64'h0);
    random_phase(180);

    write_reg(CFG_MODE, MODE_SV39);
    write_reg(CFG_BASE, 44'd0);
    issue(REQ_CLEAR, 50'h0, 56'h0, 10'h0, 1'b0, 2'd0, 64'h0);
    random_phase(240);

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
